// File: src/mfps_pkg.sv
// Shared types and constants of the matched-filter peak selector.
// No dependencies; imported by every module of the block.
package mfps_pkg;

    // Sizes of the datapath
    localparam int MAX_COMPONENTS = 8;
    localparam int MAX_RUNGS      = 1024;
    localparam int SAMPLE_BITS    = 12;

    localparam int CCNT_W  = 4;     // component_count register
    localparam int RCNT_W  = 11;    // rung_count register
    localparam int CPOS_W  = 3;     // component position
    localparam int IDX_W   = 10;    // rung index
    localparam int ACC_W   = 27;    // signed rung accumulator
    localparam int SCORE_W = 51;    // energy
    localparam int MUL_W   = 27;    // shared multiplier operands
    localparam int PROD_W  = 2 * MUL_W;

    localparam int IN_W  = 24;      // sample, template_value
    localparam int OUT_W = 128;     // rung_index, rung_score, best_index, best_score

    // APB register map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_USE_TEMPLATE    = 2'd0;
    localparam logic [1:0] REG_COMPONENT_COUNT = 2'd1;
    localparam logic [1:0] REG_RUNG_COUNT      = 2'd2;

    // Effective configuration handed to the sequencer
    typedef struct packed {
        logic              use_template;
        logic [CCNT_W-1:0] ncomp;   // 1..MAX_COMPONENTS
        logic [RCNT_W-1:0] nrung;   // 1..MAX_RUNGS
    } t_cfg;

endpackage

// File: src/mfps_mul.sv
// Shared signed multiplier of the peak selector: component products and the
// final correlation square both go through it. Uses mfps_pkg.
module mfps_mul
    import mfps_pkg::*;
(
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    // One full signed product, registered by the caller
    assign o_p = i_a * i_b;

endmodule

// File: src/mfps_cfg.sv
// APB register file of the peak selector; clamps the counts to their legal range.
// Uses mfps_pkg.
module mfps_cfg
    import mfps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic              r_use_template;
    logic [CCNT_W-1:0] r_ccount;
    logic [RCNT_W-1:0] r_rcount;
    logic              w_wr;
    logic [1:0]        w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_reg  = paddr[3:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_template <= 1'b0;
            r_ccount       <= CCNT_W'(1);
            r_rcount       <= RCNT_W'(1);
        end else if (w_wr) begin
            unique case (w_reg)
                REG_USE_TEMPLATE:    r_use_template <= pwdata[0];
                REG_COMPONENT_COUNT: r_ccount       <= pwdata[CCNT_W-1:0];
                REG_RUNG_COUNT:      r_rcount       <= pwdata[RCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_reg)
            REG_USE_TEMPLATE:    prdata = {{(DATA_W-1){1'b0}}, r_use_template};
            REG_COMPONENT_COUNT: prdata = {{(DATA_W-CCNT_W){1'b0}}, r_ccount};
            REG_RUNG_COUNT:      prdata = {{(DATA_W-RCNT_W){1'b0}}, r_rcount};
            default:             prdata = '0;
        endcase
    end

    // Zero acts as one, oversized counts saturate
    always_comb begin
        o_cfg.use_template = r_use_template;
        if (r_ccount == '0)
            o_cfg.ncomp = CCNT_W'(1);
        else if (r_ccount > CCNT_W'(MAX_COMPONENTS))
            o_cfg.ncomp = CCNT_W'(MAX_COMPONENTS);
        else
            o_cfg.ncomp = r_ccount;
        if (r_rcount == '0)
            o_cfg.nrung = RCNT_W'(1);
        else if (r_rcount > RCNT_W'(MAX_RUNGS))
            o_cfg.nrung = RCNT_W'(MAX_RUNGS);
        else
            o_cfg.nrung = r_rcount;
    end

endmodule

// File: src/matched_filter_peak_select.sv
// Matched-filter peak selector. Each input item is one rung component; every component is
// first accepted and then gets one multiply-accumulate on the shared 27x27 multiplier. After
// the last component of a rung the block compares and loads the result; in template mode the
// same multiplier first squares the correlation. The result waits in an output register; the
// block stalls only if a new result is ready while the previous one has not been taken.
module matched_filter_peak_select
    import mfps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // [11:0] sample, [23:12] template_value
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // [9:0] rung_index, [60:10] rung_score,
                                              // [70:61] best_index, [121:71] best_score
    output logic              m_axis_tlast,   // last
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_SQR  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    t_cfg w_cfg;

    logic [1:0]                r_state;
    logic signed [MUL_W-1:0]   r_a;
    logic signed [MUL_W-1:0]   r_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;
    logic [CPOS_W-1:0]         r_cpos;
    logic [IDX_W-1:0]          r_rpos;
    logic [IDX_W-1:0]          r_best_idx;
    logic [SCORE_W-1:0]        r_best_score;
    logic [SCORE_W-1:0]        r_energy;
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_out_data;
    logic                      r_out_last;

    logic signed [SAMPLE_BITS-1:0] w_s;
    logic signed [SAMPLE_BITS-1:0] w_t;
    logic                          w_accept;
    logic                          w_rung_end;
    logic                          w_ladder_end;
    logic                          w_take_best;
    logic                          w_out_free;
    logic [IDX_W-1:0]              w_best_idx;
    logic [SCORE_W-1:0]            w_best_score;

    mfps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    mfps_mul u_mul (
        .i_a (r_a),
        .i_b (r_b),
        .o_p (w_prod)
    );

    assign w_s      = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_t      = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = s_axis_tvalid & s_axis_tready;

    // Component product folded into the rung sum
    assign n_acc      = r_acc + w_prod[ACC_W-1:0];
    assign w_rung_end = !(({1'b0, r_cpos} + CCNT_W'(1)) < w_cfg.ncomp);
    assign w_ladder_end = (({1'b0, r_rpos} + RCNT_W'(1)) >= w_cfg.nrung);

    // Running argmax, strict compare so the lowest index keeps a tie
    assign w_take_best  = (r_rpos == '0) || (r_energy > r_best_score);
    assign w_best_idx   = w_take_best ? r_rpos   : r_best_idx;
    assign w_best_score = w_take_best ? r_energy : r_best_score;
    assign w_out_free   = !r_out_valid || m_axis_tready;

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_acc        <= '0;
            r_cpos       <= '0;
            r_rpos       <= '0;
            r_best_idx   <= '0;
            r_best_score <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_a     <= MUL_W'(w_s);
                        r_b     <= w_cfg.use_template ? MUL_W'(w_t) : MUL_W'(w_s);
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (!w_rung_end) begin
                        r_acc   <= n_acc;
                        r_cpos  <= r_cpos + CPOS_W'(1);
                        r_state <= ST_IDLE;
                    end else if (w_cfg.use_template) begin
                        r_a     <= MUL_W'(n_acc);
                        r_b     <= MUL_W'(n_acc);
                        r_state <= ST_SQR;
                    end else begin
                        // sign-extended: a mode switch mid-rung can leave the sum negative
                        r_energy <= {{(SCORE_W-ACC_W){n_acc[ACC_W-1]}}, n_acc};
                        r_state  <= ST_DONE;
                    end
                end
                ST_SQR: begin
                    r_energy <= w_prod[SCORE_W-1:0];
                    r_state  <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_acc   <= '0;
                        r_cpos  <= '0;
                        r_state <= ST_IDLE;
                        if (w_ladder_end) begin
                            r_rpos       <= '0;
                            r_best_idx   <= '0;
                            r_best_score <= '0;
                        end else begin
                            r_rpos       <= r_rpos + IDX_W'(1);
                            r_best_idx   <= w_best_idx;
                            r_best_score <= w_best_score;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out_data <= {{(OUT_W-2*IDX_W-2*SCORE_W){1'b0}},
                           w_best_score, w_best_idx, r_energy, r_rpos};
            r_out_last <= w_ladder_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
